// ===== sv/fhs_pkg.sv =====
// Shared types and constants for the FITS header and sample scanner.
// No dependencies.
`default_nettype none

package fhs_pkg;

  localparam int LenBits    = 32;
  localparam int BlockBytes = 2880;
  localparam int CardBytes  = 80;
  localparam int RemBits    = $clog2(BlockBytes);

  localparam logic [2:0] StOk = 3'd0, StSimple = 3'd1, StNaxis = 3'd2, StAxis = 3'd3,
                         StBitpix = 3'd4, StNoEnd = 3'd5, StSize = 3'd6;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_space;
    logic       is_digit;
    logic       is_minus;
    logic       is_slash;
    logic       is_eq;
    logic [3:0] digit;
  } fhs_item_t;

endpackage

`default_nettype wire

// ===== sv/fhs_front.sv =====
// Front end: accepts file bytes, classifies them and queues them.
// Depends on fhs_pkg.
`default_nettype none

module fhs_front import fhs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            q_valid_o,
  output fhs_item_t       q_item_o,
  input  wire logic       q_pop_i
);

  fhs_item_t  mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       push;
  fhs_item_t  item;

  always_comb begin
    item.data     = data_byte_i;
    item.last     = last_byte_i;
    item.is_space = (data_byte_i == 8'h20);
    item.is_digit = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
    item.is_minus = (data_byte_i == 8'h2d);
    item.is_slash = (data_byte_i == 8'h2f);
    item.is_eq    = (data_byte_i == 8'h3d);
    item.digit    = 4'(data_byte_i - 8'h30);
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (q_pop_i) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item;
  end

endmodule

`default_nettype wire

// ===== sv/fhs_back.sv =====
// Back end: card parser, END sizing sequence, sample OR and result register.
// Depends on fhs_pkg.
`default_nettype none

module fhs_back import fhs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire fhs_item_t  q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      status_o,
  output logic [31:0]     header_bytes_o,
  output logic [31:0]     image_bytes_o,
  output logic [31:0]     footer_bytes_o,
  output logic [4:0]      unused_low_bits_o,
  output logic [1:0]      components_o
);

  typedef enum logic [2:0] {PhHeader, PhCalcA, PhCalcB, PhData, PhDone} phase_e;
  typedef enum logic [2:0] {NsStart, NsMinus, NsDigits, NsFail, NsDone} num_e;

  localparam logic [63:0] NmSimple = 64'("SIMPLE"), NmBitpix = 64'("BITPIX"),
                          NmNaxis = 64'("NAXIS"), NmNaxis1 = 64'("NAXIS1"),
                          NmNaxis2 = 64'("NAXIS2"), NmBayer = 64'("BAYERPAT"),
                          NmEnd = 64'("END"), NmComment = 64'("COMMENT");
  localparam logic [32:0] MaxNeg = 33'h080000000;
  localparam logic [32:0] MaxPos = 33'h07fffffff;
  localparam logic [32:0] Clamp  = 33'h080000001;

  function automatic logic kw_match(input logic [63:0] kw, input logic [3:0] klen,
                                    input logic [63:0] nm, input int n);
    logic hit, ok;
    int   s, i;
    hit = 1'b0;
    for (s = 0; s < 8; s++) begin
      ok = (s + n <= int'(klen));
      for (i = 0; i < 8; i++) begin
        if (i < s) begin
          ok = ok && (kw[8*i +: 8] == 8'h20);
        end else if (i < s + n) begin
          ok = ok && (kw[8*i +: 8] == nm[8*(n-1-i+s) +: 8]);
        end else if (i < int'(klen)) begin
          ok = ok && (kw[8*i +: 8] == 8'h20);
        end
      end
      hit = hit || ok;
    end
    return hit;
  endfunction

  phase_e              phase_q, phase_d;
  num_e                nst_q, nst_d;
  logic [LenBits-1:0]  bc_q, bc_d;
  logic [RemBits-1:0]  rem_q, rem_d;
  logic [6:0]          col_q, col_d;
  logic [63:0]         kw_q, kw_d;
  logic                eq_q, eq_d, cut_q, cut_d, neg_q, neg_d;
  logic [7:0]          vch_q, vch_d;
  logic [1:0]          vcnt_q, vcnt_d;
  logic [32:0]         acc_q, acc_d;
  logic [31:0]         bpp_q, bpp_d, axw_q, axw_d, axh_q, axh_d;
  logic                bayer_q, bayer_d, fin_q, fin_d;
  logic [2:0]          err_q, err_d;
  logic [LenBits:0]    hl_q, hl_d;
  logic [LenBits-1:0]  il_q, il_d;
  logic [63:0]         prod_q, prod_d;
  logic [15:0]         sor_q, sor_d;

  logic                emit, out_valid_q;
  logic [2:0]          st;
  logic [4:0]          unused;
  logic [LenBits+1:0]  hl_il;
  logic [LenBits:0]    foot, pos_off, pad;
  logic [35:0]         acc_t;
  logic [64:0]         img;
  logic [6:0]          col_n;
  logic [3:0]          klen;
  logic                finish, num_ok, take_ok, is_cmt, is_end;
  logic [31:0]         num_val;
  fhs_item_t           it;

  assign it      = q_item_i;
  assign q_pop_o = q_valid_i && !fin_q &&
                   (phase_q inside {PhHeader, PhData, PhDone});
  assign emit    = fin_q && (phase_q inside {PhHeader, PhData, PhDone}) &&
                   (!out_valid_q || !out_stall_i);

  always_comb begin
    phase_d = phase_q; nst_d = nst_q; bc_d = bc_q; rem_d = rem_q;
    col_d = col_q; kw_d = kw_q; eq_d = eq_q; cut_d = cut_q; neg_d = neg_q;
    vch_d = vch_q; vcnt_d = vcnt_q; acc_d = acc_q; bpp_d = bpp_q;
    axw_d = axw_q; axh_d = axh_q; bayer_d = bayer_q; fin_d = fin_q;
    err_d = err_q; hl_d = hl_q; il_d = il_q; prod_d = prod_q; sor_d = sor_q;
    col_n = col_q + 7'd1;
    finish = 1'b0; klen = '0; is_cmt = 1'b0; is_end = 1'b0;
    acc_t = '0; num_ok = 1'b0; take_ok = 1'b0; num_val = '0;
    pos_off = {1'b0, bc_q} - hl_q;
    pad = (rem_q == '0) ? '0 : (LenBits+1)'(BlockBytes) - (LenBits+1)'(rem_q);
    img = {prod_q, 1'b0};

    if (q_pop_o) begin
      if (bc_q != '1) begin
        bc_d  = bc_q + 1'b1;
        rem_d = (rem_q == RemBits'(BlockBytes - 1)) ? '0 : rem_q + 1'b1;
      end
      if (it.last) fin_d = 1'b1;
      case (phase_q)
        PhHeader: begin
          if (col_q < 7'd8) begin
            kw_d[8*col_q[2:0] +: 8] = it.data;
          end else if (col_q == 7'd8) begin
            eq_d = it.is_eq;
          end else if (!cut_q) begin
            if (it.is_slash) begin
              cut_d = 1'b1;
            end else begin
              if (!it.is_space) begin
                if (vcnt_q == 2'd0) vch_d = it.data;
                if (vcnt_q != 2'd2) vcnt_d = vcnt_q + 2'd1;
              end
              case (nst_q)
                NsStart: begin
                  if (it.is_minus) begin
                    neg_d = 1'b1; nst_d = NsMinus;
                  end else if (it.is_digit) begin
                    acc_d = 33'(it.digit); nst_d = NsDigits;
                  end else if (!it.is_space) begin
                    nst_d = NsFail;
                  end
                end
                NsMinus: begin
                  if (it.is_digit) begin
                    acc_d = 33'(it.digit); nst_d = NsDigits;
                  end else begin
                    nst_d = NsFail;
                  end
                end
                NsDigits: begin
                  if (it.is_digit) begin
                    acc_t = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 36'(it.digit);
                    acc_d = (acc_t > 36'(MaxNeg)) ? Clamp : acc_t[32:0];
                  end else begin
                    nst_d = NsDone;
                  end
                end
                default: ;
              endcase
            end
          end
          col_d = col_n;
          finish = (col_n >= 7'(CardBytes)) || it.last;
          if (finish) begin
            klen   = (col_n < 7'd8) ? col_n[3:0] : 4'd8;
            is_cmt = kw_match(kw_d, klen, NmComment, 7);
            is_end = kw_match(kw_d, klen, NmEnd, 3);
            num_ok = (nst_d == NsDigits) || (nst_d == NsDone);
            if (neg_d) begin
              take_ok = num_ok && (acc_d <= MaxNeg);
              num_val = 32'(33'd0 - acc_d);
            end else begin
              take_ok = num_ok && (acc_d <= MaxPos);
              num_val = acc_d[31:0];
            end
            if (is_cmt) begin
            end else if (is_end) begin
              phase_d = PhCalcA;
            end else if (col_n > 7'd8 && eq_d) begin
              if (kw_match(kw_d, klen, NmSimple, 6)) begin
                if (!(vcnt_d == 2'd1 && vch_d == 8'h54)) begin
                  err_d = StSimple; phase_d = PhDone;
                end
              end else if (kw_match(kw_d, klen, NmBitpix, 6)) begin
                if (take_ok) bpp_d = num_val;
              end else if (kw_match(kw_d, klen, NmNaxis, 5)) begin
                if (!(vcnt_d == 2'd1 && vch_d == 8'h32)) begin
                  err_d = StNaxis; phase_d = PhDone;
                end
              end else if (kw_match(kw_d, klen, NmNaxis1, 6)) begin
                if (take_ok) axw_d = num_val;
              end else if (kw_match(kw_d, klen, NmNaxis2, 6)) begin
                if (take_ok) axh_d = num_val;
              end else if (kw_match(kw_d, klen, NmBayer, 8)) begin
                bayer_d = 1'b1;
              end
            end
            col_d = '0; kw_d = '0; eq_d = 1'b0; vch_d = '0; vcnt_d = '0;
            acc_d = '0; cut_d = 1'b0; nst_d = NsStart; neg_d = 1'b0;
          end
        end
        PhData: begin
          if ({1'b0, bc_q} >= hl_q && pos_off < {1'b0, il_q}) begin
            if (pos_off[0]) sor_d = sor_q | {8'h00, it.data};
            else sor_d = sor_q | {it.data, 8'h00};
          end
        end
        default: ;
      endcase
    end

    case (phase_q)
      PhCalcA: begin
        if (axw_q == '1 || axh_q == '1) begin
          err_d = StAxis; phase_d = PhDone;
        end else if (bpp_q != 32'd16) begin
          err_d = StBitpix; phase_d = PhDone;
        end else begin
          hl_d = {1'b0, bc_q} + pad;
          if (axw_q[31] || axh_q[31]) begin
            err_d = StSize; phase_d = PhDone;
          end else begin
            prod_d = axw_q * axh_q;
            phase_d = PhCalcB;
          end
        end
      end
      PhCalcB: begin
        if ((img >> LenBits) != '0) begin
          err_d = StSize; phase_d = PhDone;
        end else begin
          il_d = img[LenBits-1:0]; phase_d = PhData;
        end
      end
      default: ;
    endcase

    if (emit) begin
      phase_d = PhHeader; nst_d = NsStart; bc_d = '0; rem_d = '0;
      col_d = '0; kw_d = '0; eq_d = 1'b0; cut_d = 1'b0; neg_d = 1'b0;
      vch_d = '0; vcnt_d = '0; acc_d = '0; bpp_d = '1; axw_d = '1; axh_d = '1;
      bayer_d = 1'b0; fin_d = 1'b0; err_d = '0; hl_d = '0; il_d = '0; sor_d = '0;
    end
  end

  always_comb begin
    hl_il  = {1'b0, hl_q} + (LenBits+2)'(il_q);
    foot   = {1'b0, bc_q} - hl_q - (LenBits+1)'(il_q);
    unused = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (sor_q[i]) unused = 5'(i);
    end
    case (phase_q)
      PhHeader: st = StNoEnd;
      PhDone:   st = err_q;
      default: begin
        if (hl_q > {1'b0, bc_q} || hl_il > (LenBits+2)'(bc_q)) st = StSize;
        else st = StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader; nst_q <= NsStart; bc_q <= '0; rem_q <= '0;
      col_q <= '0; kw_q <= '0; eq_q <= 1'b0; cut_q <= 1'b0; neg_q <= 1'b0;
      vch_q <= '0; vcnt_q <= '0; acc_q <= '0; bpp_q <= '1; axw_q <= '1;
      axh_q <= '1; bayer_q <= 1'b0; fin_q <= 1'b0; err_q <= '0; hl_q <= '0;
      il_q <= '0; prod_q <= '0; sor_q <= '0; out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d; nst_q <= nst_d; bc_q <= bc_d; rem_q <= rem_d;
      col_q <= col_d; kw_q <= kw_d; eq_q <= eq_d; cut_q <= cut_d; neg_q <= neg_d;
      vch_q <= vch_d; vcnt_q <= vcnt_d; acc_q <= acc_d; bpp_q <= bpp_d;
      axw_q <= axw_d; axh_q <= axh_d; bayer_q <= bayer_d; fin_q <= fin_d;
      err_q <= err_d; hl_q <= hl_d; il_q <= il_d; prod_q <= prod_d; sor_q <= sor_d;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_o          <= st;
      header_bytes_o    <= (st == StOk) ? 32'(hl_q) : '0;
      image_bytes_o     <= (st == StOk) ? 32'(il_q) : '0;
      footer_bytes_o    <= (st == StOk) ? 32'(foot) : '0;
      unused_low_bits_o <= (st == StOk) ? unused : '0;
      components_o      <= bayer_q ? 2'd2 : 2'd1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/fits_header_and_sample_scan.sv =====
// Top level of the FITS header and sample scanner.
// Depends on fhs_pkg, fhs_front and fhs_back.
//
// Input channel: one file byte per request (data_byte_i, last_byte_i),
// taken when in_valid_i is high and in_stall_o is low. Output channel: one
// result per file, offered on out_valid_o and held while out_stall_i is high.
// Throughput is one byte per cycle while in_stall_o is low. After the END
// card the parser sizes the image in PhCalcA (one 32x32 multiply), then in
// PhCalcB (a range check); the two-entry byte queue absorbs part of that
// and in_stall_o covers the rest. The last byte sets fin_q, which loads the
// result register, after the sizing states if END is the final card. A
// result waiting on a stalled receiver does not block the next file's bytes
// until another result is ready. Reset clears the queue and all parser
// state; the parser returns to that state (bar prod_q) for the next file.
`default_nettype none

module fits_header_and_sample_scan import fhs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      header_bytes_o,
  output logic [31:0]      image_bytes_o,
  output logic [31:0]      footer_bytes_o,
  output logic [4:0]       unused_low_bits_o,
  output logic [1:0]       components_o
);

  logic      q_valid, q_pop;
  fhs_item_t q_item;

  fhs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .last_byte_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  fhs_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .status_o, .header_bytes_o, .image_bytes_o,
    .footer_bytes_o, .unused_low_bits_o, .components_o
  );

endmodule

`default_nettype wire

// ===== sv/fhs_checker.sv =====
// Port-level checks on the FITS scanner result channel, bound to the top.
// Depends on fhs_pkg and fits_header_and_sample_scan.
`default_nettype none

module fhs_checker import fhs_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_o,
  input wire logic [31:0] header_bytes_o,
  input wire logic [31:0] image_bytes_o,
  input wire logic [31:0] footer_bytes_o,
  input wire logic [4:0]  unused_low_bits_o,
  input wire logic [1:0]  components_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (components_o == 2'd1 || components_o == 2'd2))
    else $error("bad component count");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> header_bytes_o == '0 &&
      image_bytes_o == '0 && footer_bytes_o == '0 && unused_low_bits_o == '0)
    else $error("error result carries lengths");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StSize && unused_low_bits_o <= 5'd16)
    else $error("result field out of range");

endmodule

bind fits_header_and_sample_scan fhs_checker u_fhs_checker (.*);

`default_nettype wire
